FILE: rtl/xbpr_pkg.sv
// shared types, constants and decode helpers for the x86 branch predecode block
// no dependencies; compiled first
package xbpr_pkg;

    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 4;
    localparam int ADDR_W       = 64;
    localparam int DISP_W       = 32;
    localparam int LOW_BYTES    = 8;
    localparam int HIGH_BYTES   = 7;
    localparam int MAX_BYTES_DEF = 15;

    // legacy prefix bytes
    localparam logic [7:0] PFX_LOCK  = 8'hF0;
    localparam logic [7:0] PFX_REP   = 8'hF3;
    localparam logic [7:0] PFX_REPNE = 8'hF2;
    localparam logic [7:0] PFX_CS    = 8'h2E;
    localparam logic [7:0] PFX_SS    = 8'h36;
    localparam logic [7:0] PFX_DS    = 8'h3E;
    localparam logic [7:0] PFX_ES    = 8'h26;
    localparam logic [7:0] PFX_FS    = 8'h64;
    localparam logic [7:0] PFX_GS    = 8'h65;

    // branch opcodes
    localparam logic [7:0] OP_JMP_REL32  = 8'hE9;
    localparam logic [7:0] OP_JMP_REL8   = 8'hEB;
    localparam logic [7:0] OP_CALL_REL32 = 8'hE8;
    localparam logic [7:0] OP_LOOP_FIRST = 8'hE0;
    localparam logic [7:0] OP_LOOP_LAST  = 8'hE3;
    localparam logic [7:0] OP_ESCAPE     = 8'h0F;
    localparam logic [3:0] OP_JCC8_HI    = 4'h7;
    localparam logic [3:0] OP_JCC32_HI   = 4'h8;

    typedef struct packed {
        logic [HIGH_BYTES*BYTE_W-1:0] bytes_high;
        logic [LOW_BYTES*BYTE_W-1:0]  bytes_low;
        logic [LEN_W-1:0]             length;
        logic [ADDR_W-1:0]            instr_address;
        logic [ADDR_W-1:0]            target_address;
    } in_beat_t;

    typedef struct packed {
        logic [LEN_W-1:0]             prefix_count;
        logic                         is_branch;
        logic signed [DISP_W-1:0]     displacement;
        logic [LOW_BYTES*BYTE_W-1:0]  patched_low;
        logic [HIGH_BYTES*BYTE_W-1:0] patched_high;
        logic                         was_patched;
    } out_beat_t;

    function automatic logic is_prefix(input logic [7:0] b);
        return b == PFX_LOCK || b == PFX_REP || b == PFX_REPNE || b == PFX_CS ||
               b == PFX_SS || b == PFX_DS || b == PFX_ES || b == PFX_FS ||
               b == PFX_GS;
    endfunction

endpackage

FILE: rtl/xbpr_stream_if.sv
// valid/ready stream channel carrying one beat of payload type T
// depends on nothing; payload types come from xbpr_pkg at the point of use
interface xbpr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/x86_branch_predecode_retarget.sv
// x86 relative branch predecoder and rel32 retargeter, top level
// depends on xbpr_pkg and xbpr_stream_if
//
//   channel  dir  payload     meaning
//   instr    in   in_beat_t   instruction bytes, length, address, new target
//   result   out  out_beat_t  prefix count, branch flag, displacement, bytes
//
// one instruction per cycle sustained while result.ready holds; an instr beat
// reaches the result beat through input register, decode logic, result register
// rst_n clears both stage valid flags asynchronously; payload is not reset
// a stalled result holds its register and the input stage keeps filling
// behind it, so up to two beats are held before instr.ready drops
module x86_branch_predecode_retarget #(
    parameter int MAX_BYTES = xbpr_pkg::MAX_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    xbpr_stream_if.sink   instr,
    xbpr_stream_if.source result
);

    localparam int NBYTES   = xbpr_pkg::LOW_BYTES + xbpr_pkg::HIGH_BYTES;
    // room for a rel32 field read starting up to three bytes past the last byte
    localparam int BUF_N    = NBYTES + 6;
    localparam int IDX_W    = $clog2(BUF_N);
    localparam logic [xbpr_pkg::LEN_W-1:0] MAX_LEN = xbpr_pkg::LEN_W'(MAX_BYTES);

    xbpr_pkg::in_beat_t  s1_data_reg;
    logic                s1_valid_reg;
    xbpr_pkg::out_beat_t out_data_reg;
    logic                out_valid_reg;
    xbpr_pkg::out_beat_t out_next;
    logic                s2_load;

    logic [xbpr_pkg::LEN_W-1:0] len_sat;
    logic [NBYTES*8-1:0]        raw_bytes;
    logic [7:0]                 ibyte [BUF_N];
    logic [7:0]                 pbyte [NBYTES];
    logic [xbpr_pkg::LEN_W-1:0] pfx_cnt;
    logic [IDX_W-1:0]           op_idx;
    logic [7:0]                 op;
    logic [7:0]                 op2;
    logic                       is_rel8;
    logic                       is_rel32_1;
    logic                       is_jcc32;
    logic [IDX_W-1:0]           field;
    logic [31:0]                field_val;
    logic                       do_patch;
    logic [31:0]                new_rel;

    // handshake: stage 1 frees when it moves into the result register
    assign s2_load      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign instr.ready  = !s1_valid_reg || s2_load;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (instr.ready)
        begin
            s1_valid_reg <= instr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (instr.valid && instr.ready)
        begin
            s1_data_reg <= instr.data;
        end
    end

    // saturate length and mask bytes past it
    always_comb
    begin
        len_sat   = (s1_data_reg.length > MAX_LEN) ? MAX_LEN : s1_data_reg.length;
        raw_bytes = {s1_data_reg.bytes_high, s1_data_reg.bytes_low};
        for (int i = 0; i < BUF_N; i++)
        begin
            if (i < NBYTES && IDX_W'(i) < IDX_W'(len_sat))
            begin
                ibyte[i] = raw_bytes[8*(i % NBYTES) +: 8];
            end
            else
            begin
                ibyte[i] = 8'h00;
            end
        end
    end

    // prefix count: first non-prefix byte, masked bytes are never prefixes
    always_comb
    begin
        pfx_cnt = xbpr_pkg::LEN_W'(NBYTES);
        for (int i = NBYTES; i >= 0; i--)
        begin
            if (!xbpr_pkg::is_prefix(ibyte[i]))
            begin
                pfx_cnt = xbpr_pkg::LEN_W'(i);
            end
        end
    end

    // opcode classification
    always_comb
    begin
        op_idx     = IDX_W'(pfx_cnt);
        op         = ibyte[op_idx];
        op2        = ibyte[op_idx + IDX_W'(1)];
        is_rel8    = (op >= xbpr_pkg::OP_LOOP_FIRST && op <= xbpr_pkg::OP_LOOP_LAST) ||
                     op == xbpr_pkg::OP_JMP_REL8 || op[7:4] == xbpr_pkg::OP_JCC8_HI;
        is_rel32_1 = op == xbpr_pkg::OP_CALL_REL32 || op == xbpr_pkg::OP_JMP_REL32;
        is_jcc32   = op == xbpr_pkg::OP_ESCAPE && op2[7:4] == xbpr_pkg::OP_JCC32_HI;
        field      = is_jcc32 ? op_idx + IDX_W'(2) : op_idx + IDX_W'(1);
        field_val  = {ibyte[field + IDX_W'(3)], ibyte[field + IDX_W'(2)],
                      ibyte[field + IDX_W'(1)], ibyte[field]};
        do_patch   = (is_rel32_1 || is_jcc32) &&
                     ({1'b0, field} + (IDX_W+1)'(4) <= (IDX_W+1)'(len_sat));
        new_rel    = s1_data_reg.target_address[31:0] - s1_data_reg.instr_address[31:0]
                     - 32'(s1_data_reg.length);
    end

    // rel32 rewrite into the byte image
    always_comb
    begin
        for (int i = 0; i < NBYTES; i++)
        begin
            pbyte[i] = ibyte[i];
            for (int k = 0; k < 4; k++)
            begin
                if (do_patch && field + IDX_W'(k) == IDX_W'(i))
                begin
                    pbyte[i] = new_rel[8*k +: 8];
                end
            end
        end
    end

    // result assembly
    always_comb
    begin
        out_next.prefix_count = pfx_cnt;
        out_next.is_branch    = (s1_data_reg.length >= xbpr_pkg::LEN_W'(2)) &&
                                (is_rel8 || is_rel32_1 || is_jcc32);
        if (is_rel8)
        begin
            out_next.displacement = {{24{op2[7]}}, op2};
        end
        else if (is_rel32_1 || is_jcc32)
        begin
            out_next.displacement = field_val;
        end
        else
        begin
            out_next.displacement = '0;
        end
        for (int i = 0; i < xbpr_pkg::LOW_BYTES; i++)
        begin
            out_next.patched_low[8*i +: 8] = pbyte[i];
        end
        for (int i = 0; i < xbpr_pkg::HIGH_BYTES; i++)
        begin
            out_next.patched_high[8*i +: 8] = pbyte[xbpr_pkg::LOW_BYTES + i];
        end
        out_next.was_patched = do_patch;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            out_data_reg <= out_next;
        end
    end

    // checks
    a_patch_is_branch: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.was_patched |-> result.data.is_branch)
        else $error("rewritten rel32 on a non-branch");

    a_prefix_in_len: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> pfx_cnt <= len_sat)
        else $error("prefix count runs past the length");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        instr.valid && instr.ready |=> s1_valid_reg)
        else $error("accepted beat lost from the input stage");

    a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> out_valid_reg)
        else $error("decoded beat lost from the result stage");

endmodule
